// File: rtl/hnd_pkg.sv
// Shared types, register codes and the 64-bit population count used by the
// descriptor matcher. No dependencies.
`default_nettype none

package hnd_pkg;

  // Fixed field widths
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned ENTRY_W  = 10;
  localparam int unsigned WIDX_W   = 2;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned LIMIT_W  = 9;
  localparam int unsigned POP_W    = 7;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd64;

  // Input item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register select, taken from paddr[2]
  localparam logic REG_REF_COUNT  = 1'b0;
  localparam logic REG_DIST_LIMIT = 1'b1;

  // SWAR masks
  localparam logic [31:0] M_PAIR   = 32'h5555_5555;
  localparam logic [31:0] M_NIBBLE = 32'h3333_3333;
  localparam logic [31:0] M_BYTE   = 32'h0F0F_0F0F;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  function automatic logic [5:0] pop32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [7:0]  s;
    a = v - ((v >> 1) & M_PAIR);
    b = (a & M_NIBBLE) + ((a >> 2) & M_NIBBLE);
    c = (b + (b >> 4)) & M_BYTE;
    s = c[7:0] + c[15:8] + c[23:16] + c[31:24];
    return s[5:0];
  endfunction

  function automatic logic [POP_W-1:0] pop64(input logic [WORD_W-1:0] v);
    return POP_W'(pop32(v[31:0])) + POP_W'(pop32(v[63:32]));
  endfunction

endpackage

`default_nettype wire

// File: rtl/hnd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module hnd_ram #(
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/hamming_nearest_descriptor_match.sv
// Top level of the brute-force Hamming descriptor matcher: APB register
// port, reference store, scan sequencer and shared popcount/compare unit.
// Depends on hnd_pkg and hnd_ram.
//
// Usage
//   Items are offered on kind/entry_index/word_index/descriptor_word/
//   query_index and transfer on a rising edge with start high and busy low.
//   A load item (kind 0) writes one 64-bit word of a reference entry. A
//   query item (kind 1) stores one query word; the item carrying the last
//   word starts a scan of entries 0 .. min(ref_count, REF_DEPTH)-1.
//   The scan reads one reference word per cycle from the single RAM read
//   port and folds it through one 64-bit popcount unit. When ref_count is
//   zero no word is read and the result follows directly; busy is high
//   throughout the query, so no new item is taken until it is done.
//   The result (result_query_index, match_found, match_index,
//   best_distance) is shown for exactly one cycle with result_valid high;
//   the receiver cannot stall it and must take it in that cycle.
//   Registers sit on an APB port: ref_count at 0x0, distance_limit at 0x4;
//   write them only while the block is idle.
//   Reset clears the sequencer and sets ref_count to 0 and distance_limit
//   to 64. The reference store is not cleared: read only written entries.
`default_nettype none

module hamming_nearest_descriptor_match
  import hnd_pkg::*;
#(
  parameter int unsigned REF_DEPTH  = 1024,
  parameter int unsigned DESC_WORDS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               kind,
  input  wire logic [ENTRY_W-1:0] entry_index,
  input  wire logic [WIDX_W-1:0]  word_index,
  input  wire logic [WORD_W-1:0]  descriptor_word,
  input  wire logic [TAG_W-1:0]   query_index,
  // result channel
  output logic                    result_valid,
  output logic [TAG_W-1:0]        result_query_index,
  output logic                    match_found,
  output logic [ENTRY_W-1:0]      match_index,
  output logic [LIMIT_W-1:0]      best_distance,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  localparam int unsigned MEM_DEPTH = REF_DEPTH * DESC_WORDS;
  localparam int unsigned AW   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned IW   = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(REF_DEPTH + 1);
  localparam int unsigned WW   = (DESC_WORDS > 1) ? $clog2(DESC_WORDS) : 1;
  localparam int unsigned DW   = $clog2(64 * DESC_WORDS + 1);
  localparam int unsigned CMPW = (DW > LIMIT_W) ? DW : LIMIT_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [COUNT_W-1:0] ref_count;
  logic [LIMIT_W-1:0] distance_limit;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count      <= '0;
      distance_limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_REF_COUNT:  ref_count      <= pwdata[COUNT_W-1:0];
        REG_DIST_LIMIT: distance_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_REF_COUNT:  prdata = APB_DW'(ref_count);
      REG_DIST_LIMIT: prdata = APB_DW'(distance_limit);
      default:        prdata = '0;
    endcase
  end

  // Clamp the search count to the store depth
  logic [CW-1:0] count_sat;
  assign count_sat = (32'(ref_count) > 32'(REF_DEPTH)) ? CW'(REF_DEPTH) : CW'(ref_count);

  // ---------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------
  state_t state;
  logic   accept;
  logic   word_ok;
  logic   load_wr;
  logic   query_wr;
  logic   query_go;

  assign busy     = (state != ST_IDLE);
  assign accept   = start & ~busy;
  assign word_ok  = 32'(word_index) < 32'(DESC_WORDS);
  assign load_wr  = accept & (kind == KIND_LOAD) & word_ok
                  & (32'(entry_index) < 32'(REF_DEPTH));
  assign query_wr = accept & (kind == KIND_QUERY) & word_ok;
  // The last query word launches the scan
  assign query_go = query_wr & (32'(word_index) == 32'(DESC_WORDS - 1));

  // Query words, the last one included, kept in a small register file
  logic [WORD_W-1:0] query_words [DESC_WORDS];

  always_ff @(posedge clk) begin
    if (query_wr) begin
      query_words[WW'(word_index)] <= descriptor_word;
    end
  end

  // ---------------------------------------------------------------------
  // Reference store
  // ---------------------------------------------------------------------
  logic [AW-1:0]     load_addr;
  logic [AW-1:0]     scan_addr;
  logic              scan_rd;
  logic [WORD_W-1:0] ref_word;

  assign load_addr = AW'(32'(entry_index) * 32'(DESC_WORDS) + 32'(word_index));

  hnd_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (MEM_DEPTH),
    .ADDR_W (AW)
  ) u_ref_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (load_addr),
    .wr_data (descriptor_word),
    .rd_en   (scan_rd),
    .rd_addr (scan_addr),
    .rd_data (ref_word)
  );

  // ---------------------------------------------------------------------
  // Scan sequencer: one reference word per cycle, entries in order
  // ---------------------------------------------------------------------
  logic [CW-1:0]    e_cnt;
  logic [WW-1:0]    w_cnt;
  logic             w_last;
  logic             e_last;
  logic [TAG_W-1:0] tag;

  assign scan_rd = (state == ST_SCAN);
  assign w_last  = (32'(w_cnt) == 32'(DESC_WORDS - 1));
  assign e_last  = (32'(e_cnt) + 32'd1 == 32'(count_sat));

  // Pipeline tags: s1 travels with the RAM read, s2 with the popcount
  logic             s1_valid;
  logic             s1_first;
  logic             s1_last;
  logic [WW-1:0]    s1_w;
  logic [IW-1:0]    s1_e;
  logic             s2_valid;
  logic             s2_first;
  logic             s2_last;
  logic [IW-1:0]    s2_e;
  logic [POP_W-1:0] s2_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (query_go) begin
            // Nothing to search: go straight to the result
            state <= (count_sat == '0) ? ST_DRAIN : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (w_last && e_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      e_cnt     <= '0;
      w_cnt     <= '0;
      scan_addr <= '0;
      if (query_go) begin
        tag <= query_index;
      end
    end else if (state == ST_SCAN) begin
      scan_addr <= scan_addr + AW'(1);
      if (w_last) begin
        w_cnt <= '0;
        e_cnt <= e_cnt + CW'(1);
      end else begin
        w_cnt <= w_cnt + WW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Shared popcount and compare unit
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= scan_rd;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (w_cnt == '0);
    s1_last  <= w_last;
    s1_w     <= w_cnt;
    s1_e     <= e_cnt[IW-1:0];
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_e     <= s1_e;
    s2_pop   <= pop64(ref_word ^ query_words[s1_w]);
  end

  logic [DW-1:0]      acc;
  logic [DW-1:0]      dist_sum;
  logic [LIMIT_W-1:0] best;
  logic [IW-1:0]      best_idx;
  logic               found;

  // Restart the sum on the first word of each entry
  assign dist_sum = (s2_first ? '0 : acc) + DW'(s2_pop);

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      best     <= distance_limit;
      best_idx <= '0;
      found    <= 1'b0;
    end else if (s2_valid) begin
      acc <= dist_sum;
      // Strictly below: ties keep the lower entry
      if (s2_last && (CMPW'(dist_sum) < CMPW'(best))) begin
        best     <= LIMIT_W'(dist_sum);
        best_idx <= s2_e;
        found    <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result strobe: one cycle once the pipeline has drained
  // ---------------------------------------------------------------------
  logic done;
  assign done = (state == ST_DRAIN) && !s1_valid && !s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      result_query_index <= tag;
      match_found        <= found;
      match_index        <= ENTRY_W'(best_idx);
      best_distance      <= best;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_strobe_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held longer than one cycle");

  a_no_match_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !match_found) |->
      (match_index == '0) && (best_distance == distance_limit))
    else $error("no-match result carries stale index or distance");

  a_match_below_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && match_found) |-> (best_distance < distance_limit))
    else $error("reported match not below the distance limit");

  a_pipe_only_busy: assert property (@(posedge clk) disable iff (rst)
    (s1_valid || s2_valid) |-> busy)
    else $error("scan pipeline active while idle");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    query_go |=> busy)
    else $error("completed query did not start a scan");

endmodule

`default_nettype wire
